[design/fvcw_pkg.sv]
// Shared constants, types and tables of the flow vector color wheel.
// Holds the arctangent table, the 55-entry wheel and the control codes.
// No dependencies; the CORDIC cell and the top level import it.
`default_nettype none

package fvcw_pkg;

   // Fixed field and datapath widths
   localparam int MAG_W     = 16;   // magnitudes and max_motion
   localparam int ANG_W     = 32;   // binary angle, full turn = 2^32
   localparam int FRAC_W    = 16;   // interpolation fraction, Q0.16
   localparam int RATIO_W   = 17;   // magnitude / norm in Q1.16, up to 1.0
   localparam int CHAN_W    = 8;    // one color channel
   localparam int COLOR_W   = 24;   // 255 * color in Q16
   localparam int IDX_W     = 6;    // wheel index
   localparam int WHEEL_SIZE = 55;
   localparam int ATAN_LEN  = 24;

   // Command codes
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_MEASURE = 2'd1;
   localparam logic [1:0] CMD_RENDER  = 2'd2;

   // Wheel segment lengths
   localparam int SEG_RY = 15;
   localparam int SEG_YG = 6;
   localparam int SEG_GC = 4;
   localparam int SEG_CB = 11;
   localparam int SEG_BM = 13;
   localparam int SEG_MR = 6;
   localparam int FULL   = 255;

   // atan(2^-i) as binary angles
   localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // One wheel entry is {red, green, blue}
   typedef logic [3*CHAN_W-1:0] wheel_tab_type [WHEEL_SIZE];

   // Build the wheel at elaboration
   function automatic wheel_tab_type build_wheel();
      wheel_tab_type t;
      int j;
      int r;
      int g;
      int b;
      for (int k = 0; k < WHEEL_SIZE; k++) begin
         j = k;
         r = 0;
         g = 0;
         b = 0;
         if (j < SEG_RY) begin
            r = FULL; g = FULL * j / SEG_RY;
         end else if ((j - SEG_RY) < SEG_YG) begin
            j = j - SEG_RY;
            r = FULL - FULL * j / SEG_YG; g = FULL;
         end else if ((j - SEG_RY - SEG_YG) < SEG_GC) begin
            j = j - SEG_RY - SEG_YG;
            g = FULL; b = FULL * j / SEG_GC;
         end else if ((j - SEG_RY - SEG_YG - SEG_GC) < SEG_CB) begin
            j = j - SEG_RY - SEG_YG - SEG_GC;
            g = FULL - FULL * j / SEG_CB; b = FULL;
         end else if ((j - SEG_RY - SEG_YG - SEG_GC - SEG_CB) < SEG_BM) begin
            j = j - SEG_RY - SEG_YG - SEG_GC - SEG_CB;
            r = FULL * j / SEG_BM; b = FULL;
         end else begin
            j = j - SEG_RY - SEG_YG - SEG_GC - SEG_CB - SEG_BM;
            r = FULL; b = FULL - FULL * j / SEG_MR;
         end
         t[k] = {CHAN_W'(r), CHAN_W'(g), CHAN_W'(b)};
      end
      return t;
   endfunction

   localparam wheel_tab_type WHEEL_TAB = build_wheel();

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_DIVIDE,
      ST_PHASE,
      ST_BLEND,
      ST_WRITE
   } state_type;

endpackage

`default_nettype wire

[design/fvcw_req_if.sv]
// Request channel: one flow vector and a command per transfer.
// Depends on nothing; width follows FLOW_BITS.
`default_nettype none

interface fvcw_req_if #(
   parameter int FLOW_BITS = 16
) ();
   logic                        valid;
   logic                        ready;
   logic [1:0]                  command;
   logic signed [FLOW_BITS-1:0] flow_x;
   logic signed [FLOW_BITS-1:0] flow_y;
   logic                        flow_valid;

   modport source (output valid, command, flow_x, flow_y, flow_valid, input ready);
   modport sink   (input valid, command, flow_x, flow_y, flow_valid, output ready);
endinterface

`default_nettype wire

[design/fvcw_rsp_if.sv]
// Response channel: one RGB color per transfer.
// Depends on nothing.
`default_nettype none

interface fvcw_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

[design/fvcw_cordic_cell.sv]
// One vectoring CORDIC cell: rotates (x,y) toward the x axis by atan(2^-STAGE).
// Uses the arctangent table of fvcw_pkg.
`default_nettype none

module fvcw_cordic_cell #(
   parameter int CW    = 27,
   parameter int STAGE = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [CW-1:0]          x_in,
   input  wire logic signed [CW-1:0]          y_in,
   input  wire logic [fvcw_pkg::ANG_W-1:0]    z_in,
   output logic                               out_valid,
   output logic signed [CW-1:0]               x_out,
   output logic signed [CW-1:0]               y_out,
   output logic [fvcw_pkg::ANG_W-1:0]         z_out
);
   import fvcw_pkg::*;

   logic                 valid_ff;
   logic signed [CW-1:0] x_ff, x_in_n;
   logic signed [CW-1:0] y_ff, y_in_n;
   logic [ANG_W-1:0]     z_ff, z_in_n;
   logic signed [CW-1:0] dx, dy;

   // Rotate one micro step; hold once the y residue is zero
   always_comb begin
      dx = y_in >>> STAGE;
      dy = x_in >>> STAGE;
      x_in_n = x_in;
      y_in_n = y_in;
      z_in_n = z_in;
      if (y_in == '0) begin
         x_in_n = x_in;
      end else if (!y_in[CW-1]) begin
         x_in_n = x_in + dx;
         y_in_n = y_in - dy;
         z_in_n = z_in + ATAN_TAB[STAGE];
      end else begin
         x_in_n = x_in - dx;
         y_in_n = y_in + dy;
         z_in_n = z_in - ATAN_TAB[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Hand the vector to the next cell
   always_ff @(posedge clock) begin
      x_ff <= x_in_n;
      y_ff <= y_in_n;
      z_ff <= z_in_n;
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;

endmodule

`default_nettype wire

[design/fvcw_isqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on nothing outside this file.
`default_nettype none

module fvcw_isqrt #(
   parameter int RAD_W = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [RAD_W-1:0]   radicand,
   output logic                    done,
   output logic [RAD_W/2-1:0]      root,
   output logic                    rem_nonzero
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ROOT_W+2:0] rem_sh, trial;

   // Bring down two radicand bits and try a root bit of one
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (ROOT_W+1)'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done        = done_ff;
   assign root        = root_ff;
   assign rem_nonzero = |rem_ff;

endmodule

`default_nettype wire

[design/fvcw_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`default_nettype none

module fvcw_div #(
   parameter int DVD_W = 32,
   parameter int DVS_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   sh, diff;
   logic             ge;

   // Shift in one dividend bit, subtract when it fits
   always_comb begin
      sh     = {rem_ff, dvd_ff[DVD_W-1]};
      diff   = sh - {1'b0, dvs_ff};
      ge     = sh >= {1'b0, dvs_ff};
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

[design/flow_vector_color_wheel_unit.sv]
// Top level of the flow vector color wheel: sequencer, CORDIC cell row,
// square root and divider units, wheel blend and output register.
// Depends on fvcw_pkg, fvcw_req_if, fvcw_rsp_if, fvcw_cordic_cell, fvcw_isqrt, fvcw_div.
//
//   channel  direction  carries
//   req_bus  in         command, flow_x, flow_y, flow_valid
//   rsp_bus  out        red, green, blue (render only)
//   csr_*    in         max_motion write
//
// A render runs the square root unit and then the divider; a measure runs only the
// square root unit. Start frame, invalid measure and command 3 never leave idle.
// The angle runs through CORDIC_STAGES cells in parallel with the square root.
// A finished color waits in the output register while the next vector is taken;
// only a second color stalls on rsp_bus.ready. Reset clears the frame maximum to 1.0.
`default_nettype none

module flow_vector_color_wheel_unit #(
   parameter int FLOW_BITS     = 16,
   parameter int FRAC_BITS     = 6,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   fvcw_req_if.sink                         req_bus,
   fvcw_rsp_if.source                       rsp_bus,
   input  wire logic                        csr_write_enable,
   input  wire logic [fvcw_pkg::MAG_W-1:0]  csr_write_data
);
   import fvcw_pkg::*;

   localparam int CW     = FLOW_BITS + 11;
   localparam int SUM_W  = 2 * FLOW_BITS;
   localparam int RAD_W  = SUM_W + 32;
   localparam int ROOT_W = RAD_W / 2;
   localparam int CMP_W  = (SUM_W > 2 * MAG_W) ? SUM_W : 2 * MAG_W;
   localparam int MAGX_W = (FLOW_BITS + 1 > MAG_W + 1) ? FLOW_BITS + 1 : MAG_W + 1;
   localparam int PROD_W = 41;
   localparam int POS_W  = ANG_W + IDX_W;
   localparam logic [MAG_W-1:0] MAX_RESET = MAG_W'(1) << FRAC_BITS;

   state_type state_ff, state_in;

   logic [MAG_W-1:0]            max_motion_ff;
   logic [MAG_W-1:0]            frame_max_ff;
   logic [1:0]                  cmd_ff;
   logic                        black_ff;
   logic signed [FLOW_BITS-1:0] x_ff, y_ff;
   logic [SUM_W-1:0]            sqx_ff, sqy_ff, s_ff, s_in;
   logic [MAG_W-1:0]            norm_ff, norm_in;
   logic [2*MAG_W-1:0]          norm_sq_ff;
   logic                        inside_ff;
   logic [RATIO_W-1:0]          r_ff;
   logic [ANG_W-1:0]            z_ff;
   logic [POS_W-1:0]            p_ff;
   logic [COLOR_W-1:0]          c_ff [3];
   logic signed [SUM_W-1:0]     sqx_in, sqy_in;

   logic                        accept, out_free;
   logic                        req_ready, sqrt_start, div_start, load_out;

   logic                        sqrt_done, rem_nz;
   logic [ROOT_W-1:0]           root;
   logic                        div_done;
   logic [ROOT_W-1:0]           quot;
   logic [MAGX_W-1:0]           mag_ext;
   logic [MAG_W-1:0]            mag;

   logic                        rsp_valid_ff;
   logic [CHAN_W-1:0]           chan_ff [3];
   logic [CHAN_W-1:0]           chan_in [3];

   // CORDIC cell row
   logic                        cv   [CORDIC_STAGES+1];
   logic signed [CW-1:0]        cx   [CORDIC_STAGES+1];
   logic signed [CW-1:0]        cy   [CORDIC_STAGES+1];
   logic [ANG_W-1:0]            cz   [CORDIC_STAGES+1];
   logic signed [CW-1:0]        px, py;

   // Wheel lookup and blend
   logic [IDX_W-1:0]            k0, k1;
   logic [FRAC_W-1:0]           f;
   logic [FRAC_W:0]             wf;
   logic [3*CHAN_W-1:0]         e0, e1;
   logic [COLOR_W:0]            c_in [3];

   assign accept   = req_bus.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.command == CMD_MEASURE && req_bus.flow_valid) begin
                  state_in = ST_SQUARE;
               end else if (req_bus.command == CMD_RENDER) begin
                  state_in = req_bus.flow_valid ? ST_SQUARE : ST_WRITE;
               end
            end
         end
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = (cmd_ff == CMD_RENDER) ? ST_DIVIDE : ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: state_in = ST_BLEND;
         ST_BLEND: state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready  = 1'b1;
         ST_SUM:   sqrt_start = 1'b1;
         ST_ROOT:  div_start  = sqrt_done && (cmd_ff == CMD_RENDER);
         ST_WRITE: load_out   = out_free;
         default:  req_ready  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_motion_ff <= '0;
      end else if (csr_write_enable) begin
         max_motion_ff <= csr_write_data;
      end
   end

   // Magnitude: ceil of the root, saturated
   assign mag_ext = MAGX_W'(root[ROOT_W-1:16]) + MAGX_W'(rem_nz);
   assign mag     = (mag_ext > MAGX_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : mag_ext[MAG_W-1:0];

   // Frame maximum: reset on start, raise on measure
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_max_ff <= MAX_RESET;
      end else if (accept && req_bus.command == CMD_START) begin
         frame_max_ff <= MAX_RESET;
      end else if (state_ff == ST_ROOT && sqrt_done && cmd_ff == CMD_MEASURE &&
                   mag > frame_max_ff) begin
         frame_max_ff <= mag;
      end
   end

   // Latch the item
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_bus.command;
         black_ff <= !req_bus.flow_valid;
         x_ff     <= req_bus.flow_x;
         y_ff     <= req_bus.flow_y;
      end
   end

   // Squares, sum, norm and its square
   assign sqx_in  = x_ff * x_ff;
   assign sqy_in  = y_ff * y_ff;
   assign s_in    = sqx_ff + sqy_ff;
   always_comb begin
      norm_in = (max_motion_ff != '0) ? max_motion_ff : frame_max_ff;
      if (norm_in == '0) begin
         norm_in = MAG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SQUARE) begin
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         norm_ff <= norm_in;
      end
      if (state_ff == ST_SUM) begin
         s_ff       <= s_in;
         norm_sq_ff <= norm_ff * norm_ff;
      end
      if (state_ff == ST_DIVIDE) begin
         inside_ff <= CMP_W'(s_ff) <= CMP_W'(norm_sq_ff);
      end
      if (div_done) begin
         r_ff <= quot[RATIO_W-1:0];
      end
   end

   fvcw_isqrt #(
      .RAD_W (RAD_W)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .start       (sqrt_start),
      .radicand    ({s_in, 32'd0}),
      .done        (sqrt_done),
      .root        (root),
      .rem_nonzero (rem_nz)
   );

   fvcw_div #(
      .DVD_W (ROOT_W),
      .DVS_W (MAG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (root),
      .divisor  (norm_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // Feed the cell row: scale by 256, fold into the right half plane
   always_comb begin
      px = {{(CW-FLOW_BITS){req_bus.flow_x[FLOW_BITS-1]}}, req_bus.flow_x} <<< 8;
      py = {{(CW-FLOW_BITS){req_bus.flow_y[FLOW_BITS-1]}}, req_bus.flow_y} <<< 8;
      cv[0] = accept && req_bus.command == CMD_RENDER && req_bus.flow_valid;
      cz[0] = '0;
      cx[0] = px;
      cy[0] = py;
      if (px[CW-1]) begin
         cx[0] = -px;
         cy[0] = -py;
         cz[0] = {1'b1, {(ANG_W-1){1'b0}}};
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      fvcw_cordic_cell #(
         .CW    (CW),
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .x_in      (cx[i]),
         .y_in      (cy[i]),
         .z_in      (cz[i]),
         .out_valid (cv[i+1]),
         .x_out     (cx[i+1]),
         .y_out     (cy[i+1]),
         .z_out     (cz[i+1])
      );
   end

   // Capture the angle as it leaves the row
   always_ff @(posedge clock) begin
      if (cv[CORDIC_STAGES]) begin
         z_ff <= cz[CORDIC_STAGES];
      end
      if (state_ff == ST_PHASE) begin
         p_ff <= POS_W'(z_ff) * POS_W'(WHEEL_SIZE - 1);
      end
   end

   // Interpolate between neighboring wheel entries
   assign k0 = p_ff[POS_W-1:ANG_W];
   assign k1 = (k0 == IDX_W'(WHEEL_SIZE - 1)) ? '0 : k0 + 1'b1;
   assign f  = p_ff[ANG_W-1:ANG_W-FRAC_W];
   assign wf = {1'b1, {FRAC_W{1'b0}}} - (FRAC_W+1)'(f);
   assign e0 = WHEEL_TAB[k0];
   assign e1 = WHEEL_TAB[k1];

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [COLOR_W-1:0] d;
      logic [PROD_W-1:0]  blend;
      logic [COLOR_W+1:0] dark;

      assign c_in[ch] = (COLOR_W+1)'(e0[(2-ch)*CHAN_W +: CHAN_W]) * (COLOR_W+1)'(wf) +
                        (COLOR_W+1)'(e1[(2-ch)*CHAN_W +: CHAN_W]) * (COLOR_W+1)'(f);

      always_ff @(posedge clock) begin
         if (state_ff == ST_BLEND) begin
            c_ff[ch] <= c_in[ch][COLOR_W-1:0];
         end
      end

      // Blend toward white inside the norm, dim by 3/4 outside
      assign d     = COLOR_W'(FULL << FRAC_W) - c_ff[ch];
      assign blend = (PROD_W'(FULL) << 32) - PROD_W'(r_ff) * PROD_W'(d);
      assign dark  = (COLOR_W+2)'(c_ff[ch]) * (COLOR_W+2)'(3);

      always_comb begin
         if (black_ff) begin
            chan_in[ch] = '0;
         end else if (inside_ff) begin
            chan_in[ch] = blend[39:32];
         end else begin
            chan_in[ch] = dark[COLOR_W+1:COLOR_W-6];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         chan_ff <= chan_in;
      end
   end

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.red   = chan_ff[0];
   assign rsp_bus.green = chan_ff[1];
   assign rsp_bus.blue  = chan_ff[2];

   // Unit completions only arrive in the states that wait for them
   a_sqrt_in_root: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_ROOT)
      else $error("square root finished outside the root state");

   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_angle_busy: assert property (@(posedge clock) disable iff (reset)
      cv[CORDIC_STAGES] |-> state_ff != ST_IDLE)
      else $error("angle left the cell row while idle");

   a_frame_max_nonzero: assert property (@(posedge clock) disable iff (reset)
      frame_max_ff != '0)
      else $error("frame maximum dropped to zero");

endmodule

`default_nettype wire

[tb/sv/fvcw_color_checker.sv]
// Color checker: watches the request and response channels of the flow vector
// color wheel, predicts each RGB transfer and compares it. Depends on fvcw_pkg,
// fvcw_req_if and fvcw_rsp_if.
`timescale 1ns / 100ps

module fvcw_color_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   fvcw_req_if              req_bus,
   fvcw_rsp_if              rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   output int               mismatch_count,
   output int               colors_pending
);
   import fvcw_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   localparam logic [31:0] ATAN_LUT [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   color_type   color_queue[$];
   logic [15:0] norm_reg;
   logic [15:0] frame_peak;

   // Integer square root, floor
   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Binary angle of (x, y) by CORDIC vectoring
   function automatic logic [31:0] vector_angle(longint x, longint y);
      longint cx;
      longint cy;
      longint dx;
      longint dy;
      logic [31:0] z;
      cx = x * 256;
      cy = y * 256;
      z = 0;
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         z = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
         if (cy == 0) break;
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy > 0) begin
            cx += dx; cy -= dy; z += ATAN_LUT[i];
         end else begin
            cx -= dx; cy += dy; z -= ATAN_LUT[i];
         end
      end
      return z;
   endfunction

   // One wheel entry as {red, green, blue}
   function automatic logic [23:0] wheel_color(int k);
      int r;
      int g;
      int b;
      r = 0; g = 0; b = 0;
      if (k < 15) begin
         r = 255; g = 255 * k / 15;
      end else if (k < 21) begin
         r = 255 - 255 * (k - 15) / 6; g = 255;
      end else if (k < 25) begin
         g = 255; b = 255 * (k - 21) / 4;
      end else if (k < 36) begin
         g = 255 - 255 * (k - 25) / 11; b = 255;
      end else if (k < 49) begin
         r = 255 * (k - 36) / 13; b = 255;
      end else begin
         r = 255; b = 255 - 255 * (k - 49) / 6;
      end
      return {r[7:0], g[7:0], b[7:0]};
   endfunction

   // Render one valid vector
   function automatic color_type render_color(longint x, longint y, logic [63:0] sq,
                                              logic [63:0] norm);
      logic [63:0] pos;
      logic [63:0] frac;
      logic [63:0] ratio;
      logic [63:0] c;
      logic [63:0] v;
      logic [23:0] e0;
      logic [23:0] e1;
      int k0;
      logic [7:0] chan [3];
      pos = 64'(vector_angle(x, y)) * 54;
      k0 = int'(pos >> 32);
      frac = (pos >> 16) & 64'hFFFF;
      e0 = wheel_color(k0);
      e1 = wheel_color((k0 + 1) % 55);
      ratio = 0;
      if (sq <= norm * norm) ratio = root_floor(sq << 32) / norm;
      for (int ch = 0; ch < 3; ch++) begin
         c = 64'(e0[23 - 8 * ch -: 8]) * (65536 - frac) + 64'(e1[23 - 8 * ch -: 8]) * frac;
         if (sq <= norm * norm) v = ((64'd255 << 32) - ratio * ((64'd255 << 16) - c)) >> 32;
         else v = (c * 3) >> 18;
         chan[ch] = v[7:0];
      end
      return '{chan[0], chan[1], chan[2]};
   endfunction

   assign colors_pending = color_queue.size();

   // Predict on each request transfer, track register writes
   always @(posedge clock) begin
      longint x;
      longint y;
      logic [63:0] sq;
      logic [63:0] m;
      logic [63:0] norm;
      if (reset) begin
         norm_reg <= 0;
         frame_peak <= 16'd64;
      end else begin
         if (csr_write_enable) norm_reg <= csr_write_data;
         if (req_bus.valid && req_bus.ready) begin
            x = longint'(req_bus.flow_x);
            y = longint'(req_bus.flow_y);
            sq = 64'(x * x + y * y);
            case (req_bus.command)
               CMD_START: frame_peak <= 16'd64;
               CMD_MEASURE: begin
                  if (req_bus.flow_valid) begin
                     m = root_floor(sq);
                     if (m * m < sq) m++;
                     if (m > 64'hFFFF) m = 64'hFFFF;
                     if (m[15:0] > frame_peak) frame_peak <= m[15:0];
                  end
               end
               CMD_RENDER: begin
                  if (!req_bus.flow_valid) begin
                     color_queue.push_back('0);
                  end else begin
                     norm = (norm_reg != 0) ? 64'(norm_reg) : 64'(frame_peak);
                     if (norm == 0) norm = 1;
                     color_queue.push_back(render_color(x, y, sq, norm));
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Compare each response transfer with the oldest prediction
   initial mismatch_count = 0;
   always @(posedge clock) begin
      color_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (color_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected color %h %h %h", rsp_bus.red, rsp_bus.green,
                        rsp_bus.blue);
         end else begin
            want = color_queue.pop_front();
            if (want.red !== rsp_bus.red || want.green !== rsp_bus.green ||
                want.blue !== rsp_bus.blue) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("color mismatch: expected %h %h %h, got %h %h %h",
                           want.red, want.green, want.blue,
                           rsp_bus.red, rsp_bus.green, rsp_bus.blue);
            end
         end
      end
   end

endmodule

[tb/sv/testbench.sv]
// Top of the color wheel testbench: clock, reset, stimulus and verdict.
// Depends on fvcw_pkg, the channel interfaces, the block and fvcw_color_checker.
`timescale 1ns / 100ps

module testbench;
   import fvcw_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   int          mismatch_count;
   int          colors_pending;
   int          cycle_count;
   bit          idle_enable;
   bit          hold_off;

   fvcw_req_if #(.FLOW_BITS(16)) req_bus ();
   fvcw_rsp_if rsp_bus ();

   flow_vector_color_wheel_unit i_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   fvcw_color_checker i_checker (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count), .colors_pending(colors_pending)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // Bound the run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1500000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold-off on request
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      if (hold_off) rsp_bus.ready <= 1'b0;
      else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
         rsp_bus.ready <= 1'b1;
      end else rsp_bus.ready <= 1'b1;
   end

   // Offer one item, sometimes with a random gap first; valid stays up for the next item
   task automatic send_vector(logic [1:0] cmd, logic [15:0] x, logic [15:0] y, logic v);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.flow_x <= x;
      req_bus.flow_y <= y;
      req_bus.flow_valid <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Let the block drain before a register write
   task automatic drain_and_write(logic [15:0] value);
      req_bus.valid <= 1'b0;
      while (colors_pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random vector: mostly small, sometimes full range
   function automatic logic [15:0] random_flow();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 4000)) - 2000);
         default: return 16'($signed($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   task automatic random_frame(int count);
      logic [1:0] cmd;
      send_vector(CMD_START, 0, 0, 1'b0);
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(1, 2));
         send_vector(cmd, random_flow(), random_flow(), $urandom_range(0, 7) != 0);
      end
   endtask

   initial begin
      logic [15:0] norm_set [5];
      norm_set = '{16'd0, 16'd1, 16'hFFFF, 16'd64, 16'd0};
      reset = 1'b1;
      idle_enable = 1'b1;
      hold_off = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_START;
      req_bus.flow_x = '0;
      req_bus.flow_y = '0;
      req_bus.flow_valid = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, every command, zero and invalid vectors
      send_vector(CMD_RENDER, 0, 0, 1'b1);
      send_vector(CMD_RENDER, 16'h7FFF, 16'h8000, 1'b0);
      send_vector(CMD_MEASURE, 16'h8000, 16'h8000, 1'b1);
      send_vector(CMD_RENDER, 16'h8000, 16'h8000, 1'b1);
      send_vector(CMD_RENDER, 16'h7FFF, 16'h7FFF, 1'b1);
      send_vector(CMD_RENDER, 16'h0040, 0, 1'b1);
      send_vector(CMD_RENDER, 0, 16'h0040, 1'b1);
      send_vector(CMD_RENDER, 16'hFFC0, 0, 1'b1);
      send_vector(CMD_RENDER, 0, 16'hFFC0, 1'b1);
      send_vector(CMD_MEASURE, 16'h1234, 16'h4321, 1'b0);
      send_vector(2'd3, 16'h5555, 16'hAAAA, 1'b1);
      send_vector(CMD_START, 0, 0, 1'b1);
      send_vector(CMD_RENDER, 16'h0100, 16'hFF00, 1'b1);
      send_vector(CMD_RENDER, 16'hFFFF, 16'h0001, 1'b1);

      // Hold the receiver off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 8; i++)
            send_vector(CMD_RENDER, random_flow(), random_flow(), 1'b1);
      join

      // Pause until every color is back, then sweep register settings
      for (int s = 0; s < 5; s++) begin
         drain_and_write(s == 4 ? 16'($urandom) : norm_set[s]);
         for (int f = 0; f < 5; f++) random_frame(50);
      end

      // Tail without idling
      idle_enable = 1'b0;
      random_frame(60);

      req_bus.valid <= 1'b0;
      while (colors_pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatch_count == 0 && colors_pending == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
